/* hw/rtl/fnsc_pkg.sv */
// Shared constants, codes, step table and controller/datapath interface types.
package fnsc_pkg;

	localparam int TRACK_COUNT_DEF = 35;
	localparam int TRACK_BYTES_DEF = 8192;

	// Right shift that turns an elapsed cycle gap into a nibble count.
	localparam int SHIFT_LOG2 = 5;
	// Head position plus elapsed nibbles, wide enough for any 32-bit cycle gap.
	localparam int SUM_W = 28;

	localparam logic [7:0] LATCH_MASK = 8'h7F;

	localparam logic [1:0] FUNC_BUS      = 2'd0;
	localparam logic [1:0] FUNC_LOAD_BYTE = 2'd1;
	localparam logic [1:0] FUNC_SET_LEN  = 2'd2;

	localparam logic [3:0] SW_MOTOR_OFF  = 4'd8;
	localparam logic [3:0] SW_MOTOR_ON   = 4'd9;
	localparam logic [3:0] SW_SEL0       = 4'd10;
	localparam logic [3:0] SW_SEL1       = 4'd11;
	localparam logic [3:0] SW_SHIFT      = 4'd12;
	localparam logic [3:0] SW_READ_MODE  = 4'd14;
	localparam logic [3:0] SW_WRITE_MODE = 4'd15;

	// Head move in quarter-tracks (table value doubled), by last and new phase.
	function automatic logic signed [3:0] step_delta(input logic [1:0] last,
			input logic [1:0] ph);
		logic signed [3:0] d;
		case ({last, ph})
			4'b00_00: d = 4'sd0;
			4'b00_01: d = 4'sd2;
			4'b00_10: d = 4'sd4;
			4'b00_11: d = -4'sd2;
			4'b01_00: d = -4'sd2;
			4'b01_01: d = 4'sd0;
			4'b01_10: d = 4'sd2;
			4'b01_11: d = 4'sd4;
			4'b10_00: d = -4'sd4;
			4'b10_01: d = -4'sd2;
			4'b10_10: d = 4'sd0;
			4'b10_11: d = 4'sd2;
			4'b11_00: d = 4'sd2;
			4'b11_01: d = -4'sd4;
			4'b11_10: d = -4'sd2;
			4'b11_11: d = 4'sd0;
			default:  d = 4'sd0;
		endcase
		return d;
	endfunction

	typedef struct packed {
		logic capture;
		logic apply;
		logic shift_off;
		logic finish;
		logic len_read;
		logic div_start;
		logic div_step;
		logic first_shift;
		logic shift_update;
		logic mem_read;
		logic latch_load;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_shift;
		logic motor_run;
		logic need_shift;
		logic len_ok;
		logic started;
		logic div_done;
	} stat_t;

endpackage

/* hw/rtl/floppy_nibble_stepper_controller.sv */
// Top level: two-drive nibble floppy controller behind sixteen soft switches.
// Switch, load, motor-off shift and no-nibble shift transactions end after decode; a
// shift without track data adds a length fetch, a drive's first shift also a byte read,
// and a head advance a 28-step bit-serial modulo by track length. One transaction at a
// time; a finished result waits in the output register while the next one is accepted.
// Reset (arst_n low) clears motor, drive, mode, latch, head state and length valid bits.
module floppy_nibble_stepper_controller #(
	parameter int TRACK_COUNT = fnsc_pkg::TRACK_COUNT_DEF,
	parameter int TRACK_BYTES = fnsc_pkg::TRACK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [3:0]  offset,
	input  logic        write_access,
	input  logic [31:0] cycle_now,
	input  logic        load_drive,
	input  logic [5:0]  load_track,
	input  logic [12:0] load_position,
	input  logic [7:0]  track_byte,
	input  logic [13:0] track_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data
);

	fnsc_pkg::cmd_t  cmd;
	fnsc_pkg::stat_t stat;

	fnsc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	fnsc_datapath #(
		.TRACK_COUNT (TRACK_COUNT),
		.TRACK_BYTES (TRACK_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.func          (func),
		.offset        (offset),
		.write_access  (write_access),
		.cycle_now     (cycle_now),
		.load_drive    (load_drive),
		.load_track    (load_track),
		.load_position (load_position),
		.track_byte    (track_byte),
		.track_length  (track_length),
		.read_data     (read_data)
	);

endmodule

/* hw/rtl/fnsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module fnsc_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/fnsc_ctrl.sv */
// Controller state machine: sequences decode, length fetch, modulo, byte read and output.
module fnsc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  fnsc_pkg::stat_t stat,
	output fnsc_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_LEN,
		S_DIV,
		S_MRD,
		S_MWAIT,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				if (!stat.is_shift) begin
					cmd.apply = 1'b1;
					state_d   = S_DONE;
				end else if (!stat.motor_run) begin
					cmd.shift_off = 1'b1;
					state_d       = S_DONE;
				end else if (!stat.need_shift) begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end else begin
					cmd.len_read = 1'b1;
					state_d      = S_LEN;
				end
			end
			S_LEN: begin
				if (!stat.len_ok) begin
					cmd.finish = 1'b1;
					state_d    = S_DONE;
				end else if (stat.started) begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV;
				end else begin
					cmd.first_shift = 1'b1;
					state_d         = S_MRD;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.shift_update = 1'b1;
					state_d          = S_MRD;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_MRD: begin
				cmd.mem_read = 1'b1;
				state_d      = S_MWAIT;
			end
			S_MWAIT: begin
				cmd.latch_load = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule

/* hw/rtl/fnsc_datapath.sv */
// Datapath: drive state, head stepping, length and track memories, bit-serial modulo.
module fnsc_datapath #(
	parameter int TRACK_COUNT = fnsc_pkg::TRACK_COUNT_DEF,
	parameter int TRACK_BYTES = fnsc_pkg::TRACK_BYTES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fnsc_pkg::cmd_t  cmd,
	output fnsc_pkg::stat_t stat,
	input  logic [1:0]      func,
	input  logic [3:0]      offset,
	input  logic            write_access,
	input  logic [31:0]     cycle_now,
	input  logic            load_drive,
	input  logic [5:0]      load_track,
	input  logic [12:0]     load_position,
	input  logic [7:0]      track_byte,
	input  logic [13:0]     track_length,
	output logic [7:0]      read_data
);

	localparam int HEAD_W      = $clog2(TRACK_BYTES);
	localparam int LEN_W       = $clog2(TRACK_BYTES + 1);
	localparam int QT_W        = $clog2(TRACK_COUNT * 4);
	localparam int ROWS        = 2 * TRACK_COUNT;
	localparam int ROW_W       = $clog2(ROWS);
	localparam int STORE_DEPTH = 2 * TRACK_COUNT * TRACK_BYTES;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int SUM_W       = fnsc_pkg::SUM_W;
	localparam int SL          = fnsc_pkg::SHIFT_LOG2;
	localparam int CNT_W       = $clog2(SUM_W + 1);

	// Captured transaction
	logic [1:0]  func_q;
	logic [3:0]  off_q;
	logic        wr_q;
	logic [31:0] now_q;
	logic        ld_q;
	logic [5:0]  lt_q;
	logic [12:0] lp_q;
	logic [7:0]  byte_q;
	logic [13:0] tlen_q;

	// Controller-level and per-drive state
	logic              motor_q;
	logic              drive_q;
	logic              wmode_q;
	logic [7:0]        latch_q;
	logic [QT_W-1:0]   qt_q      [2];
	logic [1:0]        phase_q   [2];
	logic [HEAD_W-1:0] head_q    [2];
	logic [31:0]       last_q    [2];
	logic              present_q [2];
	logic              started_q [2];
	logic [ROWS-1:0]   len_valid_q;

	logic [7:0]        res_q;
	logic [7:0]        read_data_q;

	// Modulo unit
	logic [LEN_W-1:0]  div_len_q;
	logic [LEN_W-1:0]  rem_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LEN_W:0]    trial;
	logic [LEN_W-1:0]  rem_d;

	logic [31:0]       diff;
	logic [31-SL:0]    nibbles;
	logic [ROW_W-1:0]  cur_row;
	logic [ROW_W-1:0]  load_row;
	logic              load_track_ok;
	logic              load_pos_ok;
	logic [AW-1:0]     store_waddr;
	logic [AW-1:0]     store_raddr;
	logic [7:0]        store_rdata;
	logic [LEN_W-1:0]  len_rdata;
	logic [LEN_W-1:0]  len_wdata;
	logic              store_we;
	logic              len_we;
	logic [QT_W+1:0]   qt_sum;
	logic [QT_W-1:0]   qt_new;

	assign diff    = now_q - last_q[drive_q];
	assign nibbles = diff[31:SL];
	assign cur_row = ROW_W'(drive_q) * ROW_W'(TRACK_COUNT) + ROW_W'(qt_q[drive_q] >> 2);
	assign load_row = ROW_W'(ld_q) * ROW_W'(TRACK_COUNT) + ROW_W'(lt_q);
	assign load_track_ok = (32'(lt_q) < TRACK_COUNT);
	assign load_pos_ok   = (32'(lp_q) < TRACK_BYTES);

	assign store_waddr = AW'(load_row) * AW'(TRACK_BYTES) + AW'(lp_q);
	assign store_raddr = AW'(cur_row) * AW'(TRACK_BYTES) + AW'(head_q[drive_q]);
	assign store_we    = cmd.apply && (func_q == fnsc_pkg::FUNC_LOAD_BYTE)
		&& load_track_ok && load_pos_ok;
	assign len_we      = cmd.apply && (func_q == fnsc_pkg::FUNC_SET_LEN) && load_track_ok;
	assign len_wdata   = (32'(tlen_q) > TRACK_BYTES) ? LEN_W'(TRACK_BYTES) : LEN_W'(tlen_q);

	fnsc_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (byte_q),
		.re    (cmd.mem_read),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	fnsc_ram #(
		.WIDTH (LEN_W),
		.DEPTH (ROWS)
	) u_len (
		.clk   (clk),
		.we    (len_we),
		.waddr (load_row),
		.wdata (len_wdata),
		.re    (cmd.len_read),
		.raddr (cur_row),
		.rdata (len_rdata)
	);

	// Head stepping with clamp to the track range
	always_comb begin
		qt_sum = $signed({2'b00, qt_q[drive_q]})
			+ fnsc_pkg::step_delta(phase_q[drive_q], off_q[2:1]);
		if ($signed(qt_sum) < 0) begin
			qt_new = '0;
		end else if ($signed(qt_sum) >= $signed((QT_W + 2)'(TRACK_COUNT * 4))) begin
			qt_new = QT_W'(TRACK_COUNT * 4 - 1);
		end else begin
			qt_new = qt_sum[QT_W-1:0];
		end
	end

	// One restoring-remainder step per cycle
	always_comb begin
		trial = {rem_q, sum_q[SUM_W-1]};
		if (trial >= {1'b0, div_len_q}) begin
			rem_d = LEN_W'(trial - {1'b0, div_len_q});
		end else begin
			rem_d = trial[LEN_W-1:0];
		end
	end

	always_comb begin
		stat.is_shift   = (func_q == fnsc_pkg::FUNC_BUS) && (off_q == fnsc_pkg::SW_SHIFT)
			&& !wmode_q;
		stat.motor_run  = motor_q;
		stat.need_shift = (|nibbles) || !started_q[drive_q];
		stat.len_ok     = (32'(qt_q[drive_q] >> 2) < TRACK_COUNT) && present_q[drive_q]
			&& len_valid_q[cur_row] && (len_rdata != '0);
		stat.started    = started_q[drive_q];
		stat.div_done   = (cnt_q == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			off_q  <= offset;
			wr_q   <= write_access;
			now_q  <= cycle_now;
			ld_q   <= load_drive;
			lt_q   <= load_track;
			lp_q   <= load_position;
			byte_q <= track_byte;
			tlen_q <= track_length;
		end
		if (cmd.div_start) begin
			div_len_q <= len_rdata;
			rem_q     <= '0;
			sum_q     <= SUM_W'(head_q[drive_q]) + SUM_W'(nibbles);
			cnt_q     <= CNT_W'(SUM_W);
		end else if (cmd.div_step) begin
			rem_q <= rem_d;
			sum_q <= {sum_q[SUM_W-2:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.out_load) begin
			read_data_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			motor_q     <= 1'b0;
			drive_q     <= 1'b0;
			wmode_q     <= 1'b0;
			latch_q     <= '0;
			res_q       <= '0;
			len_valid_q <= '0;
			for (int i = 0; i < 2; i++) begin
				qt_q[i]      <= '0;
				phase_q[i]   <= '0;
				head_q[i]    <= '0;
				last_q[i]    <= '0;
				present_q[i] <= 1'b0;
				started_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.apply) begin
				// Even switches other than shift return the latch on reads
				res_q <= ((func_q == fnsc_pkg::FUNC_BUS) && !wr_q && !off_q[0]
					&& (off_q != fnsc_pkg::SW_SHIFT)) ? latch_q : '0;
				case (func_q)
					fnsc_pkg::FUNC_SET_LEN: begin
						if (load_track_ok) begin
							len_valid_q[load_row] <= 1'b1;
							present_q[ld_q]       <= 1'b1;
						end
					end
					fnsc_pkg::FUNC_BUS: begin
						if (!off_q[3] && off_q[0] && motor_q) begin
							qt_q[drive_q]    <= qt_new;
							phase_q[drive_q] <= off_q[2:1];
						end
						case (off_q)
							fnsc_pkg::SW_MOTOR_OFF:  motor_q <= 1'b0;
							fnsc_pkg::SW_MOTOR_ON:   motor_q <= 1'b1;
							fnsc_pkg::SW_SEL0:       drive_q <= 1'b0;
							fnsc_pkg::SW_SEL1:       drive_q <= 1'b1;
							fnsc_pkg::SW_READ_MODE:  wmode_q <= 1'b0;
							fnsc_pkg::SW_WRITE_MODE: wmode_q <= 1'b1;
							default: begin
							end
						endcase
					end
					default: begin
					end
				endcase
			end
			if (cmd.shift_off) begin
				latch_q <= '0;
				res_q   <= '0;
			end
			if (cmd.finish) begin
				res_q   <= latch_q;
				latch_q <= latch_q & fnsc_pkg::LATCH_MASK;
			end
			if (cmd.first_shift) begin
				last_q[drive_q]    <= now_q;
				started_q[drive_q] <= 1'b1;
			end
			if (cmd.shift_update) begin
				head_q[drive_q] <= HEAD_W'(rem_q);
				last_q[drive_q] <= last_q[drive_q] + {nibbles, {SL{1'b0}}};
			end
			if (cmd.latch_load) begin
				res_q   <= store_rdata;
				latch_q <= store_rdata & fnsc_pkg::LATCH_MASK;
			end
		end
	end

	assign read_data = read_data_q;

endmodule

/* dv/floppy_nibble_stepper_controller_test.sv */
// Self-checking testbench for the two-drive nibble floppy controller.
module floppy_nibble_stepper_controller_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NTRACK = fnsc_pkg::TRACK_COUNT_DEF;
	localparam int NBYTES = fnsc_pkg::TRACK_BYTES_DEF;
	localparam int RANDOM_ITEMS = 1500;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [3:0] SW_NOP = 4'd13;
	localparam logic [3:0] SW_PHASE0_OFF = 4'd0;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [3:0]  offset;
		logic        write_access;
		logic [31:0] cycle_now;
		logic        load_drive;
		logic [5:0]  load_track;
		logic [12:0] load_position;
		logic [7:0]  track_byte;
		logic [13:0] track_length;
	} access_t;

	class drive_shadow;
		bit        motor, sel, wmode;
		bit [7:0]  latch;
		bit [7:0]  qtrack[2];
		bit [1:0]  phase[2];
		bit [31:0] head[2];
		bit [31:0] shift_mark[2];
		bit        present[2];
		bit        started[2];
		int        tlen[2*NTRACK];
		bit [7:0]  nibbles_stored[int];
		bit [7:0]  read_bytes_due[$];
		int        move_tab[4][4] = '{'{0, 1, 2, -1}, '{-1, 0, 1, 2},
			'{-2, -1, 0, 1}, '{1, -2, -1, 0}};

		function void clear();
			motor = 0; sel = 0; wmode = 0; latch = 0;
			foreach (qtrack[i]) begin
				qtrack[i] = 0; phase[i] = 0; head[i] = 0;
				shift_mark[i] = 0; present[i] = 0; started[i] = 0;
			end
			foreach (tlen[i]) tlen[i] = 0;
		endfunction

		function int store_key(int d, int t, int p);
			return (d * NTRACK + t) * NBYTES + p;
		endfunction

		// Store index a shift would read, or -1 when it reads nothing.
		function int shift_target(access_t a);
			bit [31:0] nib;
			int t;
			longint p;
			if (a.func != fnsc_pkg::FUNC_BUS || a.offset != fnsc_pkg::SW_SHIFT || wmode
				|| !motor) return -1;
			nib = (a.cycle_now - shift_mark[sel]) >> fnsc_pkg::SHIFT_LOG2;
			if (nib == 0 && started[sel]) return -1;
			t = qtrack[sel] >> 2;
			if (t >= NTRACK || !present[sel] || tlen[sel*NTRACK+t] == 0) return -1;
			p = head[sel];
			if (started[sel]) p = (p + longint'(nib)) % tlen[sel*NTRACK+t];
			return store_key(sel, t, int'(p));
		endfunction

		function bit reads_unwritten(access_t a);
			int k;
			k = shift_target(a);
			return k >= 0 && !nibbles_stored.exists(k);
		endfunction

		function void note_access(access_t a);
			bit [7:0] res;
			bit [31:0] nib;
			int k, t, qt, len;
			res = 0;
			if (a.func == fnsc_pkg::FUNC_LOAD_BYTE) begin
				if (a.load_track < NTRACK && a.load_position < NBYTES)
					nibbles_stored[store_key(a.load_drive, a.load_track, a.load_position)]
						= a.track_byte;
			end else if (a.func == fnsc_pkg::FUNC_SET_LEN) begin
				if (a.load_track < NTRACK) begin
					len = a.track_length > NBYTES ? NBYTES : a.track_length;
					tlen[a.load_drive*NTRACK+a.load_track] = len;
					present[a.load_drive] = 1;
				end
			end else if (a.func == fnsc_pkg::FUNC_BUS) begin
				if (a.offset < 8) begin
					if (a.offset[0] && motor) begin
						qt = qtrack[sel] + 2 * move_tab[phase[sel]][a.offset[2:1]];
						phase[sel] = a.offset[2:1];
						if (qt < 0) qt = 0;
						if (qt >= NTRACK * 4) qt = NTRACK * 4 - 1;
						qtrack[sel] = 8'(qt);
					end
				end else case (a.offset)
					fnsc_pkg::SW_MOTOR_OFF:  motor = 0;
					fnsc_pkg::SW_MOTOR_ON:   motor = 1;
					fnsc_pkg::SW_SEL0:       sel = 0;
					fnsc_pkg::SW_SEL1:       sel = 1;
					fnsc_pkg::SW_READ_MODE:  wmode = 0;
					fnsc_pkg::SW_WRITE_MODE: wmode = 1;
					fnsc_pkg::SW_SHIFT: if (!wmode) begin
						if (!motor) latch = 0;
						else begin
							k = shift_target(a);
							if (k >= 0) begin
								t = qtrack[sel] >> 2;
								nib = (a.cycle_now - shift_mark[sel]) >> fnsc_pkg::SHIFT_LOG2;
								if (started[sel]) begin
									head[sel] = 32'((longint'(head[sel]) + longint'(nib))
										% tlen[sel*NTRACK+t]);
									shift_mark[sel] += nib << fnsc_pkg::SHIFT_LOG2;
								end else begin
									shift_mark[sel] = a.cycle_now;
									started[sel] = 1;
								end
								latch = nibbles_stored.exists(k) ? nibbles_stored[k] : 8'h00;
							end
							res = latch;
						end
						latch &= fnsc_pkg::LATCH_MASK;
					end
					default: ;
				endcase
				if (!a.write_access && !a.offset[0] && a.offset != fnsc_pkg::SW_SHIFT)
					res = latch;
			end
			read_bytes_due.push_back(res);
		endfunction

		function bit check_read(bit [7:0] got, output string msg);
			bit [7:0] want;
			if (read_bytes_due.size() == 0) begin
				msg = $sformatf("read_data %02h with no transaction pending", got);
				return 0;
			end
			want = read_bytes_due.pop_front();
			msg = $sformatf("read_data %02h, expected %02h", got, want);
			return got == want;
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  func = 0;
	logic [3:0]  offset = 0;
	logic        write_access = 0;
	logic [31:0] cycle_now = 0;
	logic        load_drive = 0;
	logic [5:0]  load_track = 0;
	logic [12:0] load_position = 0;
	logic [7:0]  track_byte = 0;
	logic [13:0] track_length = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [7:0]  read_data;

	drive_shadow shadow = new();
	int errors = 0;
	int cycles = 0;
	bit quiet = 0;
	bit hold_off = 0;
	bit [31:0] bus_clock = 0;

	floppy_nibble_stepper_controller DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("floppy_nibble_stepper_controller_test: errors");
			$finish;
		end
	end

	task automatic report(string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string msg;
		if (arst_n && out_valid && !out_stall)
			if (!shadow.check_read(read_data, msg)) report(msg);
	end

	// Receiver with random stalls, and a long hold-off whenever one is requested.
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_off) begin
				out_stall = 1;
				repeat (300) @(negedge clk);
				hold_off = 0;
				out_stall = 0;
			end else if (!quiet && $urandom_range(3) == 0) begin
				n = $urandom_range(1, 8);
				out_stall = 1;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_stall = 0;
				n = $urandom_range(1, 8);
				repeat (n - 1) @(negedge clk);
			end
		end
	end

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic offer(access_t a);
		if (!quiet && $urandom_range(4) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		if (shadow.reads_unwritten(a)) a.offset = SW_NOP;
		func = a.func; offset = a.offset; write_access = a.write_access;
		cycle_now = a.cycle_now; load_drive = a.load_drive; load_track = a.load_track;
		load_position = a.load_position; track_byte = a.track_byte;
		track_length = a.track_length;
		in_valid = 1;
		do @(posedge clk); while (in_stall);
		shadow.note_access(a);
		@(negedge clk);
	endtask

	function automatic access_t blank();
		access_t a;
		a.func = fnsc_pkg::FUNC_BUS; a.offset = SW_NOP;
		a.write_access = 1'($urandom_range(1));
		a.cycle_now = bus_clock; a.load_drive = 1'($urandom_range(1));
		a.load_track = 6'($urandom_range(63)); a.load_position = 13'($urandom_range(8191));
		a.track_byte = 8'($urandom_range(255)); a.track_length = 14'($urandom_range(16383));
		return a;
	endfunction

	task automatic bus(logic [3:0] sw, logic wr, int gap);
		access_t a;
		bus_clock += 32'(gap);
		a = blank();
		a.offset = sw; a.write_access = wr;
		offer(a);
	endtask

	task automatic set_len(bit d, int t, int len);
		access_t a;
		a = blank();
		a.func = fnsc_pkg::FUNC_SET_LEN; a.load_drive = d; a.load_track = 6'(t);
		a.track_length = 14'(len);
		offer(a);
	endtask

	task automatic load(bit d, int t, int p, logic [7:0] b);
		access_t a;
		a = blank();
		a.func = fnsc_pkg::FUNC_LOAD_BYTE; a.load_drive = d; a.load_track = 6'(t);
		a.load_position = 13'(p); a.track_byte = b;
		offer(a);
	endtask

	// Give a track a length and bytes (only 8 when over 24); returns the number of transactions.
	task automatic fill_track(output int used);
		bit d;
		int t, len, n;
		d = 1'($urandom_range(1));
		t = $urandom_range(3) == 0 ? $urandom_range(34) : shadow.qtrack[d] >> 2;
		case ($urandom_range(9))
			0:       len = 0;
			1:       len = $urandom_range(8193, 16383);
			default: len = $urandom_range(1, 24);
		endcase
		n = len > 24 ? 8 : len;
		for (int p = 0; p < n; p++) load(d, t, p, 8'($urandom_range(255)));
		set_len(d, t, len);
		used = n + 1;
	endtask

	task automatic random_bus();
		logic [3:0] sw;
		int gap;
		case ($urandom_range(19))
			0, 1, 2, 3, 4, 5, 6: sw = fnsc_pkg::SW_SHIFT;
			7, 8, 9, 10:         sw = {1'b0, 2'($urandom_range(3)), 1'b1};
			11:                  sw = fnsc_pkg::SW_MOTOR_OFF;
			12, 13:              sw = fnsc_pkg::SW_MOTOR_ON;
			14:                  sw = $urandom_range(1) ? fnsc_pkg::SW_SEL0 : fnsc_pkg::SW_SEL1;
			15:                  sw = $urandom_range(3) == 0 ? fnsc_pkg::SW_WRITE_MODE
				: fnsc_pkg::SW_READ_MODE;
			default:             sw = 4'($urandom_range(15));
		endcase
		case ($urandom_range(15))
			0:       gap = 0;
			1:       gap = $urandom;
			2:       gap = $urandom_range(100000);
			default: gap = $urandom_range(400);
		endcase
		bus(sw, $urandom_range(3) == 0, gap);
	endtask

	initial begin
		access_t a;
		int done, used;
		shadow.clear();
		repeat (6) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: idle defaults, loads, first and repeated shifts, stepping.
		bus(fnsc_pkg::SW_SHIFT, 1'b0, 10);
		bus(SW_PHASE0_OFF, 1'b0, 1);
		a = blank(); a.func = FUNC_UNUSED; offer(a);
		set_len(1'b1, 63, 100);
		load(1'b0, 40, 5, 8'hAA);
		load(1'b0, 0, 0, 8'h80);
		load(1'b0, 0, 1, 8'hFF);
		load(1'b0, 0, 2, 8'h00);
		load(1'b0, 0, 3, 8'h7F);
		set_len(1'b0, 0, 4);
		set_len(1'b0, 1, 16383);
		bus(fnsc_pkg::SW_MOTOR_ON, 1'b1, 1);
		bus(fnsc_pkg::SW_READ_MODE, 1'b0, 1);
		bus(fnsc_pkg::SW_SHIFT, 1'b0, 1);
		bus(fnsc_pkg::SW_SHIFT, 1'b1, 0);
		bus(fnsc_pkg::SW_SHIFT, 1'b0, 64);
		bus(fnsc_pkg::SW_SHIFT, 1'b0, 32 * 7);
		bus(fnsc_pkg::SW_WRITE_MODE, 1'b0, 1);
		bus(fnsc_pkg::SW_SHIFT, 1'b0, 100);
		bus(fnsc_pkg::SW_READ_MODE, 1'b0, 1);
		for (int i = 0; i < 4; i++) bus({1'b0, i[1:0], 1'b1}, 1'b0, 1);
		bus(fnsc_pkg::SW_SEL1, 1'b0, 1);
		bus(fnsc_pkg::SW_SHIFT, 1'b0, 1);
		bus(fnsc_pkg::SW_MOTOR_OFF, 1'b0, 1);
		bus(fnsc_pkg::SW_SHIFT, 1'b0, 1);
		bus(fnsc_pkg::SW_SEL0, 1'b0, 1);

		// Random: mostly powered read sequences, with track fills mixed in.
		bus(fnsc_pkg::SW_MOTOR_ON, 1'b0, 1);
		done = 0;
		while (done < RANDOM_ITEMS) begin
			if (done >= 300 && done < 310) hold_off = 1;
			if (done >= RANDOM_ITEMS - 200) quiet = 1;
			if ($urandom_range(7) == 0) begin
				fill_track(used);
				done += used;
			end else begin
				random_bus();
				done++;
			end
		end
		in_valid = 0;

		while (shadow.read_bytes_due.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("floppy_nibble_stepper_controller_test: clean");
		else
			$display("floppy_nibble_stepper_controller_test: errors");
		$finish;
	end
endmodule
